// ===== hw/rtl/ffsa_pkg.sv =====
package ffsa_pkg;

	// default sizing of the segment table
	localparam int MAX_SEGMENTS = 64;
	localparam int ADDR_BITS    = 16;
	localparam int POOL_RESET   = 65535;

	// request modes
	localparam logic [1:0] MODE_ALLOC  = 2'd0;
	localparam logic [1:0] MODE_FREE   = 2'd1;
	localparam logic [1:0] MODE_QUERY  = 2'd2;
	localparam logic [1:0] MODE_REINIT = 2'd3;

	// configuration register indexes
	localparam logic CFG_POOL_SIZE = 1'b0;
	localparam logic CFG_SMALL_THR = 1'b1;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] request_size;
		logic [15:0] address;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic [15:0] granted_address;
		logic        block_allocated;
		logic [6:0]  hole_count;
		logic [15:0] allocated_bytes;
		logic [15:0] free_bytes;
		logic [15:0] largest_free;
		logic [6:0]  small_hole_count;
	} rsp_t;

	// classified command handed from front to engine
	typedef struct packed {
		logic [1:0]  op;
		logic        req_zero;
		logic [15:0] req;
		logic [15:0] addr;
	} cmd_t;

endpackage

// ===== hw/rtl/ffsa_front.sv =====
module ffsa_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ffsa_pkg::req_t     in_data,
	output logic               cmd_valid,
	input  logic               cmd_pop,
	output ffsa_pkg::cmd_t     cmd
);

	ffsa_pkg::cmd_t fifo_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	ffsa_pkg::cmd_t cls;
	logic           push;
	logic           pop;

	// classify the incoming request
	always_comb begin
		cls.op       = in_data.mode;
		cls.req_zero = (in_data.request_size == 16'd0);
		cls.req      = in_data.request_size;
		cls.addr     = in_data.address;
	end

	assign in_stall  = (cnt_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (cnt_q != 2'd0);
	assign pop       = cmd_valid && cmd_pop;
	assign cmd       = fifo_q[rd_ptr_q];

	// two-entry command queue
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

// ===== hw/rtl/ffsa_engine.sv =====
module ffsa_engine #(
	parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS,
	parameter int ADDR_BITS    = ffsa_pkg::ADDR_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_pop,
	input  ffsa_pkg::cmd_t cmd,
	input  logic [15:0]    pool_size,
	input  logic [15:0]    small_threshold,
	output logic           out_valid,
	input  logic           out_stall,
	output ffsa_pkg::rsp_t out_data
);

	localparam int AW = ADDR_BITS;
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam int WW = (AW > 16) ? AW : 16;
	localparam logic [AW-1:0] RST_POOL = AW'(ffsa_pkg::POOL_RESET);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RD    = 3'd1;
	localparam logic [2:0] ST_PROC  = 3'd2;
	localparam logic [2:0] ST_FLUSH = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	typedef struct packed {
		logic [AW-1:0] start;
		logic [AW-1:0] size;
		logic          used;
	} ent_t;

	// two banks: read the current table, write the new one
	// (each bank padded to a power of two so the bank bit can head the index)
	ent_t mem [2**(IW+1)];

	logic [2:0]    state_q;
	logic          bank_q;
	logic          init_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] r_q;
	logic [CW-1:0] w_q;
	logic [1:0]    op_q;
	logic          reqz_q;
	logic [WW-1:0] req_q;
	logic [AW-1:0] addr_q;
	ent_t          rdata_q;
	ent_t          p_q;
	logic          p_v_q;
	ent_t          w2_q;
	logic          w2_v_q;
	logic          done_q;
	logic          matched_q;
	logic          merge_q;
	logic          ok_q;
	logic [AW-1:0] grant_q;
	logic [CW-1:0] holes_q;
	logic [15:0]   ub_q;
	logic [15:0]   fb_q;
	logic [AW-1:0] largest_q;
	logic [CW-1:0] small_q;
	logic          seen_q;
	logic          isalloc_q;
	ffsa_pkg::rsp_t out_q;
	logic          out_v_q;

	ent_t          e;
	logic          rd_en;
	logic          wr_en;
	ent_t          wr_ent;
	logic          e1_v;
	ent_t          e1;
	logic          e2_v;
	ent_t          e2;
	ent_t          p_nx;
	logic          fit;
	logic          exact;
	logic          split;
	logic          hit;
	logic          target;
	logic          merge_nx;
	logic          take_cmd;
	logic          finish;

	assign cmd_pop  = (state_q == ST_IDLE);
	assign take_cmd = cmd_pop && cmd_valid;
	assign finish   = (state_q == ST_FLUSH) && !w2_v_q && !p_v_q;

	// entry under processing; right after reset the table is the reset table
	assign e = init_q ? '{start: '0, size: RST_POOL, used: 1'b0} : rdata_q;

	// per-entry transform
	always_comb begin
		fit      = (op_q == ffsa_pkg::MODE_ALLOC) && !done_q && !reqz_q && !e.used
			&& (WW'(e.size) >= req_q);
		exact    = (WW'(e.size) == req_q);
		split    = fit && !exact && (count_q < CW'(MAX_SEGMENTS));
		hit      = (op_q == ffsa_pkg::MODE_FREE) && !matched_q && (e.start == addr_q);
		target   = hit && e.used;
		merge_nx = merge_q;
		e1_v     = p_v_q;
		e1       = p_q;
		e2_v     = 1'b0;
		e2       = '{start: e.start, size: AW'(req_q), used: 1'b1};
		p_nx     = e;
		if (op_q == ffsa_pkg::MODE_ALLOC) begin
			if (fit && exact) begin
				p_nx.used = 1'b1;
			end else if (split) begin
				p_nx.start = e.start + AW'(req_q);
				p_nx.size  = e.size - AW'(req_q);
				p_nx.used  = 1'b0;
				if (p_v_q) begin
					e2_v = 1'b1;
				end else begin
					e1_v = 1'b1;
					e1   = e2;
				end
			end
		end else if (op_q == ffsa_pkg::MODE_FREE) begin
			if (target) begin
				merge_nx = 1'b1;
				if (p_v_q && !p_q.used) begin
					e1_v      = 1'b0;
					p_nx      = p_q;
					p_nx.size = p_q.size + e.size;
				end else begin
					p_nx.used = 1'b0;
				end
			end else if (merge_q) begin
				merge_nx = 1'b0;
				if (!e.used) begin
					e1_v      = 1'b0;
					p_nx      = p_q;
					p_nx.size = p_q.size + e.size;
				end
			end
		end
	end

	// memory write mux
	always_comb begin
		rd_en  = (state_q == ST_RD);
		wr_en  = 1'b0;
		wr_ent = p_q;
		case (state_q)
			ST_RD: begin
				wr_en  = w2_v_q;
				wr_ent = w2_q;
			end
			ST_PROC: begin
				wr_en  = e1_v;
				wr_ent = e1;
			end
			ST_FLUSH: begin
				wr_en  = w2_v_q || p_v_q;
				wr_ent = w2_v_q ? w2_q : p_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) rdata_q <= mem[{bank_q, r_q[IW-1:0]}];
		if (wr_en) mem[{~bank_q, w_q[IW-1:0]}] <= wr_ent;
	end

	// payload registers of the current operation
	always_ff @(posedge clk) begin
		if (take_cmd) begin
			op_q   <= cmd.op;
			reqz_q <= cmd.req_zero;
			req_q  <= WW'(cmd.req);
			addr_q <= AW'(cmd.addr);
			p_q    <= '{start: '0, size: AW'(pool_size), used: 1'b0};
		end else if (state_q == ST_PROC) begin
			p_q <= p_nx;
			if (e2_v) w2_q <= e2;
			if (fit) grant_q <= e.start;
		end
		if (take_cmd) grant_q <= '0;
		if (wr_en && !seen_q && (wr_ent.start == addr_q)) isalloc_q <= wr_ent.used;
		if (wr_en && wr_ent.used) ub_q <= ub_q + 16'(wr_ent.size);
		if (wr_en && !wr_ent.used) begin
			fb_q <= fb_q + 16'(wr_ent.size);
			if (wr_ent.size > largest_q) largest_q <= wr_ent.size;
		end
		if (take_cmd) begin
			ub_q      <= '0;
			fb_q      <= '0;
			largest_q <= '0;
			isalloc_q <= 1'b0;
		end
		if (state_q == ST_DONE && (!out_v_q || !out_stall)) begin
			out_q.ok               <= ok_q;
			out_q.granted_address  <= ok_q ? 16'(grant_q) : 16'd0;
			out_q.block_allocated  <= isalloc_q;
			out_q.hole_count       <= 7'(holes_q);
			out_q.allocated_bytes  <= ub_q;
			out_q.free_bytes       <= fb_q;
			out_q.largest_free     <= 16'(largest_q);
			out_q.small_hole_count <= 7'(small_q);
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bank_q    <= 1'b0;
			init_q    <= 1'b1;
			count_q   <= CW'(1);
			r_q       <= '0;
			w_q       <= '0;
			p_v_q     <= 1'b0;
			w2_v_q    <= 1'b0;
			done_q    <= 1'b0;
			matched_q <= 1'b0;
			merge_q   <= 1'b0;
			ok_q      <= 1'b0;
			holes_q   <= '0;
			small_q   <= '0;
			seen_q    <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (out_v_q && !out_stall) out_v_q <= 1'b0;
			if (wr_en) begin
				w_q <= w_q + CW'(1);
				if (!seen_q && (wr_ent.start == addr_q)) seen_q <= 1'b1;
				if (!wr_ent.used) begin
					holes_q <= holes_q + CW'(1);
					if (WW'(wr_ent.size) <= WW'(small_threshold)) small_q <= small_q + CW'(1);
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						r_q       <= '0;
						w_q       <= '0;
						w2_v_q    <= 1'b0;
						done_q    <= 1'b0;
						matched_q <= 1'b0;
						merge_q   <= 1'b0;
						ok_q      <= 1'b0;
						holes_q   <= '0;
						small_q   <= '0;
						seen_q    <= 1'b0;
						if (cmd.op == ffsa_pkg::MODE_REINIT) begin
							p_v_q   <= 1'b1;
							state_q <= ST_FLUSH;
						end else begin
							p_v_q   <= 1'b0;
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					if (w2_v_q) w2_v_q <= 1'b0;
					state_q <= ST_PROC;
				end
				ST_PROC: begin
					p_v_q   <= 1'b1;
					w2_v_q  <= e2_v;
					merge_q <= merge_nx;
					if (hit) matched_q <= 1'b1;
					if (fit) done_q <= 1'b1;
					if ((fit && (exact || split)) || target) ok_q <= 1'b1;
					r_q     <= r_q + CW'(1);
					state_q <= ((r_q + CW'(1)) < count_q) ? ST_RD : ST_FLUSH;
				end
				ST_FLUSH: begin
					if (w2_v_q) begin
						w2_v_q <= 1'b0;
					end else if (p_v_q) begin
						p_v_q <= 1'b0;
					end else begin
						count_q <= w_q;
						bank_q  <= ~bank_q;
						init_q  <= 1'b0;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_v_q || !out_stall) begin
						out_v_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) && (count_q <= CW'(MAX_SEGMENTS)))
		else $error("segment count out of range");
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_DONE) |-> !wr_en)
		else $error("table write outside an operation");
	a_write_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (w_q < CW'(MAX_SEGMENTS)))
		else $error("table write beyond capacity");
	a_finish_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		finish |-> (w_q != '0))
		else $error("operation left an empty table");

endmodule

// ===== hw/rtl/first_fit_segment_allocator_top.sv =====
// First-fit segment allocator with coalescing.
// Requests enter on in_valid/in_stall (payload in_data: mode, request_size,
// address); one result per request leaves on out_valid/out_stall (out_data).
// A request is taken at a clock edge with valid high and stall low.
// A two-entry queue in front holds requests while the table engine works.
// Each operation streams the segment table from one memory bank into the
// other, reading and then processing one entry at a time, and then flushes
// up to two held entries; reinitialize skips the read and only flushes the
// single free segment of the new pool. The table holds at most 64 segments.
// Results wait in an output register while out_stall is high; the engine
// holds its finished result until that register frees, and the front queue
// keeps accepting requests until it is full.
// Configuration: cfg_we with cfg_index (0 pool_size, 1 small_threshold) and
// cfg_data. The user must write them only while the block is idle; the block
// does not enforce it. pool_size takes effect at the next reinitialize.
// Reset (arst_n low) empties the queue and the output, sets pool_size to
// 65535 and small_threshold to 0, and leaves one free segment of the pool.
module first_fit_segment_allocator_top #(
	parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS,
	parameter int ADDR_BITS    = ffsa_pkg::ADDR_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  ffsa_pkg::req_t in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output ffsa_pkg::rsp_t out_data,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [15:0]    cfg_data
);

	logic [15:0]    pool_q;
	logic [15:0]    thr_q;
	logic           cmd_valid;
	logic           cmd_pop;
	ffsa_pkg::cmd_t cmd;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q <= 16'(ffsa_pkg::POOL_RESET);
			thr_q  <= 16'd0;
		end else if (cfg_we) begin
			if (cfg_index == ffsa_pkg::CFG_POOL_SIZE) pool_q <= cfg_data;
			else if (cfg_index == ffsa_pkg::CFG_SMALL_THR) thr_q <= cfg_data;
		end
	end

	ffsa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd)
	);

	ffsa_engine #(
		.MAX_SEGMENTS (MAX_SEGMENTS),
		.ADDR_BITS    (ADDR_BITS)
	) u_engine (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (cmd_valid),
		.cmd_pop         (cmd_pop),
		.cmd             (cmd),
		.pool_size       (pool_q),
		.small_threshold (thr_q),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_data        (out_data)
	);

endmodule

// ===== tb/sv/first_fit_segment_allocator_top_tb.sv =====
`timescale 1ns / 1ps

module first_fit_segment_allocator_top_tb;

	localparam int SEGS = ffsa_pkg::MAX_SEGMENTS;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	ffsa_pkg::req_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	ffsa_pkg::rsp_t out_data;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;

	int n_errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	bit hold_off = 1'b0;
	bit drain_done = 1'b0;

	always #1 clk = ~clk;

	first_fit_segment_allocator_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch on response %0d: %s got %0d expected %0d",
			n_checked, what, got, want);
		n_errors++;
	endtask

	// segment table model; predicts one response per accepted request
	class pool_scoreboard;
		logic [15:0] seg_base[SEGS];
		logic [15:0] seg_len[SEGS];
		bit          seg_busy[SEGS];
		int          seg_n;
		logic [15:0] pool_bytes = 16'd65535;
		logic [15:0] small_limit = 16'd0;
		ffsa_pkg::rsp_t pending[$];
		// recent grants, used to aim frees and queries at live blocks
		logic [15:0] granted[$];

		function new();
			rebuild();
		endfunction

		function void rebuild();
			foreach (seg_base[k]) begin
				seg_base[k] = '0;
				seg_len[k] = '0;
				seg_busy[k] = 1'b0;
			end
			seg_len[0] = pool_bytes;
			seg_n = 1;
		endfunction

		function void remove_at(int idx);
			for (int k = idx; k + 1 < seg_n; k++) begin
				seg_base[k] = seg_base[k + 1];
				seg_len[k] = seg_len[k + 1];
				seg_busy[k] = seg_busy[k + 1];
			end
			seg_n--;
		endfunction

		function bit grab(logic [15:0] want, output logic [15:0] at);
			at = '0;
			if (want == 0)
				return 1'b0;
			for (int i = 0; i < seg_n; i++) begin
				if (seg_busy[i] || seg_len[i] < want)
					continue;
				if (seg_len[i] == want) begin
					seg_busy[i] = 1'b1;
					at = seg_base[i];
					return 1'b1;
				end
				// first fit needs a split; full table ends the search
				if (seg_n >= SEGS)
					return 1'b0;
				for (int k = seg_n; k > i + 1; k--) begin
					seg_base[k] = seg_base[k - 1];
					seg_len[k] = seg_len[k - 1];
					seg_busy[k] = seg_busy[k - 1];
				end
				seg_base[i + 1] = seg_base[i] + want;
				seg_len[i + 1] = seg_len[i] - want;
				seg_busy[i + 1] = 1'b0;
				seg_len[i] = want;
				seg_busy[i] = 1'b1;
				seg_n++;
				at = seg_base[i];
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function bit release_at(logic [15:0] a);
			int i;
			for (i = 0; i < seg_n; i++)
				if (seg_base[i] == a)
					break;
			if (i >= seg_n || !seg_busy[i])
				return 1'b0;
			seg_busy[i] = 1'b0;
			if (i + 1 < seg_n && !seg_busy[i + 1]) begin
				seg_len[i] += seg_len[i + 1];
				remove_at(i + 1);
			end
			if (i > 0 && !seg_busy[i - 1]) begin
				seg_len[i - 1] += seg_len[i];
				remove_at(i);
			end
			return 1'b1;
		endfunction

		function void note_request(ffsa_pkg::req_t r);
			ffsa_pkg::rsp_t p;
			logic [15:0] at;
			bit seen;
			p = '0;
			seen = 1'b0;
			case (r.mode)
				ffsa_pkg::MODE_ALLOC: begin
					p.ok = grab(r.request_size, at);
					p.granted_address = p.ok ? at : 16'd0;
					if (p.ok)
						granted.push_back(at);
					if (granted.size() > 80)
						void'(granted.pop_front());
				end
				ffsa_pkg::MODE_FREE: p.ok = release_at(r.address);
				ffsa_pkg::MODE_REINIT: begin
					rebuild();
					granted.delete();
				end
				default: ;
			endcase
			// pool summary after the step
			for (int i = 0; i < seg_n; i++) begin
				if (!seen && seg_base[i] == r.address) begin
					seen = 1'b1;
					p.block_allocated = seg_busy[i];
				end
				if (seg_busy[i])
					p.allocated_bytes += seg_len[i];
				else begin
					p.hole_count++;
					p.free_bytes += seg_len[i];
					if (seg_len[i] > p.largest_free)
						p.largest_free = seg_len[i];
					if (seg_len[i] <= small_limit)
						p.small_hole_count++;
				end
			end
			pending.push_back(p);
		endfunction

		task check_response(ffsa_pkg::rsp_t g);
			ffsa_pkg::rsp_t w;
			if (pending.size() == 0) begin
				report_mismatch("unexpected response, queue depth", 0, 0);
				return;
			end
			w = pending.pop_front();
			if (g.ok !== w.ok) report_mismatch("ok", g.ok, w.ok);
			if (g.granted_address !== w.granted_address)
				report_mismatch("granted_address", g.granted_address, w.granted_address);
			if (g.block_allocated !== w.block_allocated)
				report_mismatch("block_allocated", g.block_allocated, w.block_allocated);
			if (g.hole_count !== w.hole_count)
				report_mismatch("hole_count", g.hole_count, w.hole_count);
			if (g.allocated_bytes !== w.allocated_bytes)
				report_mismatch("allocated_bytes", g.allocated_bytes, w.allocated_bytes);
			if (g.free_bytes !== w.free_bytes)
				report_mismatch("free_bytes", g.free_bytes, w.free_bytes);
			if (g.largest_free !== w.largest_free)
				report_mismatch("largest_free", g.largest_free, w.largest_free);
			if (g.small_hole_count !== w.small_hole_count)
				report_mismatch("small_hole_count", g.small_hole_count, w.small_hole_count);
		endtask
	endclass

	pool_scoreboard sb = new();

	// the model follows the accepted request stream
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			sb.note_request(in_data);
			n_sent++;
		end
		if (arst_n && out_valid && !out_stall) begin
			sb.check_response(out_data);
			n_checked++;
		end
	end

	// receiver: own stall pattern plus a long hold-off on request
	initial begin
		int mode_len;
		int pct;
		mode_len = 0;
		pct = 0;
		while (!drain_done) begin
			@(posedge clk);
			if (hold_off)
				out_stall <= 1'b1;
			else begin
				if (mode_len == 0) begin
					mode_len = $urandom_range(5, 60);
					case ($urandom_range(0, 3))
						0: pct = 0;
						1: pct = 20;
						2: pct = 60;
						default: pct = 90;
					endcase
				end
				mode_len--;
				out_stall <= ($urandom_range(0, 99) < pct);
			end
		end
		out_stall <= 1'b0;
	end

	task automatic write_cfg(input logic idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == ffsa_pkg::CFG_POOL_SIZE)
			sb.pool_bytes = val;
		else
			sb.small_limit = val;
	endtask

	// holds one request until accepted; valid stays up across back-to-back sends
	int gap_left = 0;
	task automatic send(input logic [1:0] m, input logic [15:0] sz, input logic [15:0] a);
		if (gap_left > 0) begin
			in_valid <= 1'b0;
			repeat (gap_left) @(posedge clk);
			gap_left = 0;
		end
		in_valid <= 1'b1;
		in_data <= '{mode: m, request_size: sz, address: a};
		do @(posedge clk); while (in_stall);
		if ($urandom_range(0, 7) == 0)
			gap_left = $urandom_range(1, 12);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	// random traffic, mostly alloc/free pairs against granted addresses
	task automatic random_phase(input int count, input int max_req);
		logic [1:0] m;
		logic [15:0] sz;
		logic [15:0] a;
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			sz = (pick % 10 == 0) ? 16'($urandom) : 16'($urandom_range(0, max_req));
			a = 16'($urandom);
			if (pick < 45)
				m = ffsa_pkg::MODE_ALLOC;
			else if (pick < 85) begin
				m = ffsa_pkg::MODE_FREE;
				if (sb.granted.size() != 0 && pick < 80)
					a = sb.granted[$urandom_range(0, sb.granted.size() - 1)];
			end else if (pick < 98) begin
				m = ffsa_pkg::MODE_QUERY;
				if (sb.granted.size() != 0 && pick < 94)
					a = sb.granted[$urandom_range(0, sb.granted.size() - 1)];
			end else
				m = ffsa_pkg::MODE_REINIT;
			send(m, sz, a);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: defaults, zero request, exact fit, splits, merges, frees
		send(ffsa_pkg::MODE_QUERY, 16'd0, 16'd0);
		send(ffsa_pkg::MODE_ALLOC, 16'd0, 16'd0);
		send(ffsa_pkg::MODE_ALLOC, 16'd100, 16'hFFFF);
		send(ffsa_pkg::MODE_ALLOC, 16'd200, 16'd100);
		send(ffsa_pkg::MODE_ALLOC, 16'd50, 16'd0);
		send(ffsa_pkg::MODE_QUERY, 16'd0, 16'd100);
		send(ffsa_pkg::MODE_FREE, 16'd0, 16'd100);
		send(ffsa_pkg::MODE_FREE, 16'd0, 16'd100);
		send(ffsa_pkg::MODE_FREE, 16'd0, 16'd7);
		send(ffsa_pkg::MODE_ALLOC, 16'd200, 16'd0);
		send(ffsa_pkg::MODE_FREE, 16'd0, 16'd0);
		send(ffsa_pkg::MODE_FREE, 16'd0, 16'd300);
		send(ffsa_pkg::MODE_FREE, 16'd0, 16'd100);
		send(ffsa_pkg::MODE_ALLOC, 16'hFFFF, 16'd0);
		send(ffsa_pkg::MODE_ALLOC, 16'd1, 16'd0);
		send(ffsa_pkg::MODE_REINIT, 16'hFFFF, 16'hFFFF);
		wait_idle();

		// tiny pool, oversize and exact fits, threshold max
		write_cfg(ffsa_pkg::CFG_POOL_SIZE, 16'd1);
		write_cfg(ffsa_pkg::CFG_SMALL_THR, 16'hFFFF);
		send(ffsa_pkg::MODE_REINIT, 16'd0, 16'd0);
		send(ffsa_pkg::MODE_ALLOC, 16'd2, 16'd0);
		send(ffsa_pkg::MODE_ALLOC, 16'd1, 16'd0);
		send(ffsa_pkg::MODE_FREE, 16'd0, 16'd0);
		wait_idle();
		write_cfg(ffsa_pkg::CFG_POOL_SIZE, 16'd0);
		send(ffsa_pkg::MODE_REINIT, 16'd0, 16'd0);
		send(ffsa_pkg::MODE_ALLOC, 16'd1, 16'd0);
		send(ffsa_pkg::MODE_QUERY, 16'd0, 16'd0);
		wait_idle();

		// full table: small pool of many small blocks
		write_cfg(ffsa_pkg::CFG_POOL_SIZE, 16'd200);
		write_cfg(ffsa_pkg::CFG_SMALL_THR, 16'd3);
		send(ffsa_pkg::MODE_REINIT, 16'd0, 16'd0);
		random_phase(250, 4);
		wait_idle();

		// long receiver hold-off while requests keep coming
		hold_off = 1'b1;
		fork
			random_phase(30, 40);
			begin
				repeat (2000) @(posedge clk);
				hold_off = 1'b0;
			end
		join
		wait_idle();

		write_cfg(ffsa_pkg::CFG_POOL_SIZE, 16'hFFFF);
		write_cfg(ffsa_pkg::CFG_SMALL_THR, 16'd500);
		send(ffsa_pkg::MODE_REINIT, 16'd0, 16'd0);
		random_phase(400, 3000);
		wait_idle();

		write_cfg(ffsa_pkg::CFG_POOL_SIZE, 16'd1000);
		write_cfg(ffsa_pkg::CFG_SMALL_THR, 16'd0);
		send(ffsa_pkg::MODE_REINIT, 16'd0, 16'd0);
		random_phase(380, 60);
		wait_idle();
		drain_done = 1'b1;

		$display("ran %0d requests (%0d responses checked) over pool sizes 0 to 65535,",
			n_sent, n_checked);
		$display("with splits, merges, full-table refusals and a long output hold-off");
		if (n_errors == 0 && sb.pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#3000000;
		$display("FAILURE");
		$finish;
	end

endmodule
